[sv/ism_pkg.sv]
// shared types and codes for the integer stack machine
package ism_pkg;

  // default number of stack entries
  localparam int unsigned STACK_DEPTH_DEF = 64;

  // token kinds
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_ADD  = 2'd1;
  localparam logic [1:0] ACT_SUB  = 2'd2;
  localparam logic [1:0] ACT_MOD  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [1:0] ERR_DIV_ZERO  = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [6:0]         depth;
    logic [1:0]         error_code;
  } out_item_t;

endpackage

[sv/integer_stack_machine_top.sv]
// integer stack machine: stack memory, top-of-stack register and iterative modulo
// push, underflow and overflow give their result in the cycle after acceptance
// add, subtract and modulo by zero pass through S_READ: one synchronous read of the second entry
// modulo runs through S_READ, S_DIV and S_FIX, with the 32-step restoring divider on the magnitudes
// busy is high while an item is in work; results cannot be stalled by the receiver
// synchronous active-low reset empties the stack; stack memory contents are not cleared
module integer_stack_machine_top #(
  parameter int unsigned STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ism_pkg::in_item_t  in_item,
  output logic              out_valid,
  output ism_pkg::out_item_t out_item
);
  import ism_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_FIX} state_t;

  state_t          state_r;
  logic [DW-1:0]   depth_r;
  logic [31:0]     top_r;
  logic [1:0]      action_r;
  logic            bneg_r;
  logic [31:0]     ma_r;
  logic [31:0]     dvd_r;
  logic [31:0]     rem_r;
  logic [4:0]      cnt_r;
  logic            out_valid_r;
  out_item_t       out_r;

  // stack memory
  logic [31:0]     stack_mem [STACK_DEPTH];
  logic [31:0]     rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [31:0]     mem_wdata;
  logic [AW-1:0]   rd_addr;

  logic            accept;
  logic            full;
  logic [DW-1:0]   depth_m1;
  logic [DW-1:0]   depth_m2;
  logic [31:0]     a_val;
  logic [31:0]     b_val;
  logic [31:0]     alu_res;
  logic [31:0]     ma_nxt;
  logic [31:0]     mb_nxt;
  logic [32:0]     rem_shift;
  logic [32:0]     trial;
  logic [31:0]     mod_res;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (depth_r == DW'(STACK_DEPTH));
  assign depth_m1  = depth_r - DW'(1);
  assign depth_m2  = depth_r - DW'(2);
  assign rd_addr   = depth_m2[AW-1:0];
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // operands: a is the cached top, b comes from memory
  assign a_val   = top_r;
  assign b_val   = rd_data_r;
  assign alu_res = (action_r == ACT_SUB) ? (b_val - a_val) : (b_val + a_val);
  assign ma_nxt  = a_val[31] ? (32'd0 - a_val) : a_val;
  assign mb_nxt  = b_val[31] ? (32'd0 - b_val) : b_val;

  // one restoring division step
  assign rem_shift = {rem_r, dvd_r[31]};
  assign trial     = rem_shift - {1'b0, ma_r};
  assign mod_res   = bneg_r ? (32'd0 - rem_r) : rem_r;

  // low 7 bits of a depth value
  function automatic logic [6:0] depth7(input logic [DW-1:0] d);
    logic [DW+6:0] ext;
    ext = {7'd0, d};
    return ext[6:0];
  endfunction

  // memory write selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = depth_r[AW-1:0];
    mem_wdata = in_item.push_value;
    unique case (state_r)
      S_IDLE: begin
        mem_we = accept && (in_item.action == ACT_PUSH) && !full;
      end
      S_READ: begin
        mem_we    = (action_r != ACT_MOD);
        mem_waddr = rd_addr;
        mem_wdata = alu_res;
      end
      S_FIX: begin
        mem_we    = 1'b1;
        mem_waddr = rd_addr;
        mem_wdata = mod_res;
      end
      S_DIV: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // synchronous stack memory, one write and one read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  // sequencer, top-of-stack cache and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            action_r <= in_item.action;
            if (in_item.action == ACT_PUSH) begin
              out_valid_r <= 1'b1;
              if (full) begin
                out_r.top_value  <= top_r;
                out_r.depth      <= depth7(depth_r);
                out_r.error_code <= ERR_OVERFLOW;
              end else begin
                top_r            <= in_item.push_value;
                depth_r          <= depth_r + DW'(1);
                out_r.top_value  <= in_item.push_value;
                out_r.depth      <= depth7(depth_r + DW'(1));
                out_r.error_code <= ERR_OK;
              end
            end else if (depth_r < DW'(2)) begin
              out_valid_r      <= 1'b1;
              out_r.top_value  <= (depth_r != '0) ? top_r : 32'd0;
              out_r.depth      <= depth7(depth_r);
              out_r.error_code <= ERR_UNDERFLOW;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          if (action_r != ACT_MOD) begin
            top_r            <= alu_res;
            depth_r          <= depth_m1;
            out_valid_r      <= 1'b1;
            out_r.top_value  <= alu_res;
            out_r.depth      <= depth7(depth_m1);
            out_r.error_code <= ERR_OK;
            state_r          <= S_IDLE;
          end else if (a_val == 32'd0) begin
            out_valid_r      <= 1'b1;
            out_r.top_value  <= top_r;
            out_r.depth      <= depth7(depth_r);
            out_r.error_code <= ERR_DIV_ZERO;
            state_r          <= S_IDLE;
          end else begin
            bneg_r  <= b_val[31];
            ma_r    <= ma_nxt;
            dvd_r   <= mb_nxt;
            rem_r   <= 32'd0;
            cnt_r   <= 5'd0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= trial[32] ? rem_shift[31:0] : trial[31:0];
          dvd_r <= {dvd_r[30:0], 1'b0};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          top_r            <= mod_res;
          depth_r          <= depth_m1;
          out_valid_r      <= 1'b1;
          out_r.top_value  <= mod_res;
          out_r.depth      <= depth7(depth_m1);
          out_r.error_code <= ERR_OK;
          state_r          <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/ism_checker.sv]
// port-level checks for the integer stack machine, bound to the top level
module ism_checker #(
  parameter int unsigned STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input ism_pkg::out_item_t out_item
);
  import ism_pkg::*;

  localparam logic [6:0] FULL7 = 7'(STACK_DEPTH);

  // an accepted item either answers at once or holds the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither answered nor started work");

  // leaving the busy phase always delivers a result
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && $past(busy) && $past(rst_n)) |-> out_valid)
    else $error("work finished without a result");

  // an empty stack reports a zero top
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.depth == 7'd0) && (STACK_DEPTH <= 127)) |->
      (out_item.top_value == 32'sd0))
    else $error("empty stack with nonzero top");

  // overflow only at a full stack
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.error_code == ERR_OVERFLOW)) |-> (out_item.depth == FULL7))
    else $error("overflow reported below full depth");

  // reset leaves the block idle and quiet
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind integer_stack_machine_top ism_checker #(
  .STACK_DEPTH(STACK_DEPTH)
) u_ism_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_item (out_item)
);
